>>> rtl/sctdt_pkg.sv
`default_nettype none

package sctdt_pkg;

	typedef enum logic [1:0] {
		OpPacked = 2'd0,
		OpDay    = 2'd1,
		OpMonth  = 2'd2,
		OpYear   = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [31:0] seconds_count;
		opcode_t     opcode;
	} request_t;

	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [4:0]  day_of_month;
		logic [3:0]  month_of_year;
		logic [6:0]  year_low;
		logic [18:0] selected_value;
	} result_t;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} date_t;

	// clock edges from the edge that takes an item to the edge that takes its result
	localparam int Latency = 12;

endpackage

`default_nettype wire

>>> rtl/sctdt_date.sv
`default_nettype none

module sctdt_date (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [15:0]        days,
	output logic               out_valid,
	output sctdt_pkg::date_t   date
);

	localparam logic [21:0] JdnOffset  = 22'd2451545;
	localparam logic [23:0] AlphaBias  = 24'd7468865;
	localparam logic [21:0] BBias      = 22'd1525;
	localparam logic [25:0] CBias      = 26'd2442;
	localparam logic [12:0] YearBase   = 13'd6715;
	localparam logic [23:0] CentFour   = 24'd1461;

	localparam int AlphaShift = 42;
	localparam int CShift     = 39;
	localparam int EShift     = 28;

	localparam logic [24:0] RecipAlpha =
		25'(((64'd1 << AlphaShift) / 64'd146097) + 64'd1);
	localparam logic [26:0] RecipC =
		27'(((64'd1 << CShift) / 64'd7305) + 64'd1);
	localparam logic [23:0] RecipE =
		24'(((64'd10000 << EShift) / 64'd306001) + 64'd1);

	// floor(30.6001 * e)
	localparam logic [8:0] MonthStart [16] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

	logic [7:0]  vld_q;

	logic [21:0] jdn_c;
	logic [21:0] jdn_s1;
	logic [23:0] v_s1;

	logic [48:0] aprod_c;
	logic [4:0]  alpha_s2;
	logic [21:0] jdn_s2;

	logic [21:0] b_c;
	logic [21:0] b_s3;
	logic [25:0] w_s3;

	logic [52:0] cprod_c;
	logic [12:0] c_s4;
	logic [21:0] b_s4;

	logic [23:0] dprod_c;
	logic [8:0]  bd_s5;
	logic [12:0] c_s5;

	logic [32:0] eprod_c;
	logic [3:0]  e_s6;
	logic [8:0]  bd_s6;
	logic [12:0] c_s6;

	logic [3:0]  mon_c;
	logic [4:0]  day_s7;
	logic [3:0]  mon_s7;
	logic [7:0]  yy_s7;

	sctdt_pkg::date_t date_s8;

	always_comb begin
		jdn_c   = JdnOffset + 22'(days);
		aprod_c = 49'(v_s1) * 49'(RecipAlpha);
		b_c     = jdn_s2 + BBias + 22'(alpha_s2) - 22'(alpha_s2[4:2]);
		cprod_c = 53'(w_s3) * 53'(RecipC);
		dprod_c = 24'(c_s4) * CentFour;
		eprod_c = 33'(bd_s5) * 33'(RecipE);
		mon_c   = (e_s6 < 4'd14) ? 4'(e_s6 - 4'd1) : 4'(e_s6 - 4'd13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		jdn_s1   <= jdn_c;
		v_s1     <= {jdn_c, 2'b00} - AlphaBias;

		alpha_s2 <= aprod_c[AlphaShift+4:AlphaShift];
		jdn_s2   <= jdn_s1;

		b_s3     <= b_c;
		w_s3     <= 26'(b_c) * 26'd20 - CBias;

		c_s4     <= cprod_c[CShift+12:CShift];
		b_s4     <= b_s3;

		bd_s5    <= 9'(b_s4 - 22'(dprod_c[23:2]));
		c_s5     <= c_s4;

		e_s6     <= eprod_c[EShift+3:EShift];
		bd_s6    <= bd_s5;
		c_s6     <= c_s5;

		day_s7   <= 5'(bd_s6 - MonthStart[e_s6]);
		mon_s7   <= mon_c;
		yy_s7    <= 8'(c_s6 - YearBase - 13'(mon_c > 4'd2));

		date_s8.day   <= day_s7;
		date_s8.month <= mon_s7;
		date_s8.year  <= (yy_s7 >= 8'd100) ? 7'(yy_s7 - 8'd100) : 7'(yy_s7);
	end

	assign out_valid = vld_q[7];
	assign date      = date_s8;

endmodule

`default_nettype wire

>>> rtl/seconds_count_to_date_time.sv
// channel   signals          direction  meaning
// request   start, item      in         seconds count and opcode, taken when start && !busy
// result    done, result     out        time of day, date and selected value, one cycle
//
// one item per clock; busy never rises, so start may stay high every cycle
// the pipeline has twelve register stages; the longest is the 26 x 27 multiply for the year
// arst_n clears the valid bits only, the data stages need no reset
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module seconds_count_to_date_time (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sctdt_pkg::request_t   item,
	output logic                  done,
	output sctdt_pkg::result_t    result
);

	localparam int DayShift = 35;
	localparam int MinShift = 19;
	localparam int HrShift  = 13;

	localparam logic [25:0] RecipDay =
		26'(((64'd1 << DayShift) / 64'd675) + 64'd1);
	localparam logic [15:0] RecipMin =
		16'(((64'd1 << MinShift) / 64'd15) + 64'd1);
	localparam logic [9:0]  RecipHr  =
		10'(((64'd1 << HrShift) / 64'd15) + 64'd1);

	typedef struct packed {
		logic [4:0]         hour;
		logic [5:0]         min;
		logic [5:0]         sec;
		sctdt_pkg::opcode_t op;
	} tm_t;

	logic accept;

	logic               v_s1;
	logic [50:0]        prod_s1;
	logic [31:0]        secs_s1;
	sctdt_pkg::opcode_t op_s1;

	logic               v_s2;
	logic [15:0]        days_s2;
	logic [25:0]        dm_s2;
	logic [31:0]        secs_s2;
	sctdt_pkg::opcode_t op_s2;

	logic [16:0]        tod_s3;
	sctdt_pkg::opcode_t op_s3;

	logic [30:0]        mprod_c;
	logic [10:0]        mtot_s4;
	logic [16:0]        tod_s4;
	sctdt_pkg::opcode_t op_s4;

	logic [18:0]        hprod_c;
	logic [4:0]         hour_s5;
	logic [5:0]         sec_s5;
	logic [10:0]        mtot_s5;
	sctdt_pkg::opcode_t op_s5;

	tm_t                tm_s6;
	tm_t                tm_dly_q [4];

	logic               date_valid;
	sctdt_pkg::date_t   date;

	logic               v_s11;
	tm_t                tm_s11;
	sctdt_pkg::date_t   date_s11;
	logic [18:0]        dayk_s11;
	logic [10:0]        monk_s11;

	logic [18:0]        packed_c;
	logic [18:0]        sel_c;

	logic               v_s12;
	sctdt_pkg::result_t result_s12;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		mprod_c  = 31'(tod_s3[16:2]) * 31'(RecipMin);
		hprod_c  = 19'(mtot_s4[10:2]) * 19'(RecipHr);
		packed_c = dayk_s11 + 19'(monk_s11) + 19'(date_s11.year);
		case (tm_s11.op)
			sctdt_pkg::OpDay:   sel_c = 19'(date_s11.day);
			sctdt_pkg::OpMonth: sel_c = 19'(date_s11.month);
			sctdt_pkg::OpYear:  sel_c = 19'(date_s11.year);
			default:            sel_c = packed_c;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s11 <= date_valid;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		// day count: seconds / 86400 as (seconds >> 7) / 675
		prod_s1 <= 51'(item.seconds_count[31:7]) * 51'(RecipDay);
		secs_s1 <= item.seconds_count;
		op_s1   <= item.opcode;

		days_s2 <= prod_s1[DayShift+15:DayShift];
		dm_s2   <= 26'(prod_s1[DayShift+15:DayShift]) * 26'd675;
		secs_s2 <= secs_s1;
		op_s2   <= op_s1;

		tod_s3  <= {10'(secs_s2[31:7] - 25'(dm_s2)), secs_s2[6:0]};
		op_s3   <= op_s2;

		mtot_s4 <= mprod_c[MinShift+10:MinShift];
		tod_s4  <= tod_s3;
		op_s4   <= op_s3;

		hour_s5 <= hprod_c[HrShift+4:HrShift];
		sec_s5  <= 6'(tod_s4 - 17'(mtot_s4) * 17'd60);
		mtot_s5 <= mtot_s4;
		op_s5   <= op_s4;

		tm_s6.hour <= hour_s5;
		tm_s6.min  <= 6'(mtot_s5 - 11'(hour_s5) * 11'd60);
		tm_s6.sec  <= sec_s5;
		tm_s6.op   <= op_s5;

		// wait for the date pipeline
		tm_dly_q[0] <= tm_s6;
		tm_dly_q[1] <= tm_dly_q[0];
		tm_dly_q[2] <= tm_dly_q[1];
		tm_dly_q[3] <= tm_dly_q[2];

		tm_s11   <= tm_dly_q[3];
		date_s11 <= date;
		dayk_s11 <= 19'(date.day) * 19'd10000;
		monk_s11 <= 11'(date.month) * 11'd100;

		result_s12.second_of_minute <= tm_s11.sec;
		result_s12.minute_of_hour   <= tm_s11.min;
		result_s12.hour_of_day      <= tm_s11.hour;
		result_s12.day_of_month     <= date_s11.day;
		result_s12.month_of_year    <= date_s11.month;
		result_s12.year_low         <= date_s11.year;
		result_s12.selected_value   <= sel_c;
	end

	sctdt_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.days      (days_s2),
		.out_valid (date_valid),
		.date      (date)
	);

	assign done   = v_s12;
	assign result = result_s12;

endmodule

`default_nettype wire

>>> rtl/sctdt_check.sv
`default_nettype none

module sctdt_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input sctdt_pkg::request_t  item,
	input logic                 done,
	input sctdt_pkg::result_t   result
);

	localparam int Lat = sctdt_pkg::Latency;

	// every accepted item comes out after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat done)
		else $error("accepted item gave no result");

	// nothing comes out that was not accepted
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##Lat !done)
		else $error("result without an accepted item");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.second_of_minute < 6'd60) && (result.minute_of_hour < 6'd60)
			&& (result.hour_of_day < 5'd24) && (result.day_of_month != 5'd0)
			&& (result.month_of_year != 4'd0) && (result.month_of_year < 4'd13)
			&& (result.year_low < 7'd100))
		else $error("result field out of range");

	// month opcode routes the month to the selected value
	a_month_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.opcode == sctdt_pkg::OpMonth)
			|-> ##Lat (result.selected_value == 19'(result.month_of_year)))
		else $error("selected value does not follow the opcode");

endmodule

bind seconds_count_to_date_time sctdt_check u_check (.*);

`default_nettype wire
